FILE: sv/aabb_pkg.sv
`default_nettype none

package aabb_pkg;

    // opcode values
    localparam logic [1:0] OP_BOTH   = 2'd0;
    localparam logic [1:0] OP_Y_ONLY = 2'd1;
    localparam logic [1:0] OP_X_ONLY = 2'd2;

    // overlap side codes
    localparam logic [2:0] SIDE_NONE   = 3'd0;
    localparam logic [2:0] SIDE_TOP    = 3'd1;
    localparam logic [2:0] SIDE_BOTTOM = 3'd2;
    localparam logic [2:0] SIDE_LEFT   = 3'd3;
    localparam logic [2:0] SIDE_RIGHT  = 3'd4;

    // per-stage load enables, stage 1 nearest the input
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } adv_t;

    // edge relations on one axis (a = moving box, b = obstacle)
    typedef struct packed {
        logic lo_before;    // a < b
        logic hi_past_lo;   // a + as > b
        logic lo_before_hi; // a < b + bs
        logic hi_past_hi;   // a + as > b + bs
    } axis_flags_t;

endpackage

`default_nettype wire

FILE: sv/aabb_axis.sv
`default_nettype none

module aabb_axis
(
    input  wire logic                      clk,
    input  wire aabb_pkg::adv_t            adv,
    input  wire logic                      en,
    input  wire logic signed [31:0]        a,
    input  wire logic        [30:0]        as,
    input  wire logic signed [31:0]        b,
    input  wire logic        [30:0]        bs,
    output      logic signed [31:0]        pos,
    output      aabb_pkg::axis_flags_t     flags
);

    // stage 1: edge ends, lower bound of overlap, doubled centres
    logic signed [31:0] s1_a_reg, s1_a_next;
    logic signed [31:0] s1_b_reg;
    logic signed [32:0] s1_ae_reg, s1_ae_next;
    logic signed [32:0] s1_be_reg, s1_be_next;
    logic signed [31:0] s1_lo_reg, s1_lo_next;
    logic signed [33:0] s1_ca_reg, s1_ca_next;
    logic signed [33:0] s1_cb_reg, s1_cb_next;
    logic               s1_en_reg;

    // stage 2: overlap extent, push direction, edge relations
    logic signed [31:0] s2_a_reg;
    logic signed [33:0] s2_ov_reg, s2_ov_next;
    logic               s2_neg_reg, s2_neg_next;
    logic               s2_en_reg;
    aabb_pkg::axis_flags_t s2_flags_reg, s2_flags_next;

    // stage 3: pushed and saturated position
    logic signed [31:0] s3_pos_reg, s3_pos_next;
    aabb_pkg::axis_flags_t s3_flags_reg;

    logic signed [32:0] s1_hi;
    logic signed [34:0] sum;

    always_comb
    begin
        s1_a_next  = a;
        s1_ae_next = 33'(a) + $signed({2'b00, as});
        s1_be_next = 33'(b) + $signed({2'b00, bs});
        s1_lo_next = (a > b) ? a : b;
        s1_ca_next = $signed({a[31], a, 1'b0}) + $signed({3'b000, as});
        s1_cb_next = $signed({b[31], b, 1'b0}) + $signed({3'b000, bs});
    end

    always_comb
    begin
        s1_hi       = (s1_ae_reg < s1_be_reg) ? s1_ae_reg : s1_be_reg;
        s2_ov_next  = 34'(s1_hi) - 34'(s1_lo_reg);
        s2_neg_next = s1_ca_reg < s1_cb_reg;
        s2_flags_next.lo_before    = s1_a_reg < s1_b_reg;
        s2_flags_next.hi_past_lo   = s1_ae_reg > 33'(s1_b_reg);
        s2_flags_next.lo_before_hi = 33'(s1_a_reg) < s1_be_reg;
        s2_flags_next.hi_past_hi   = s1_ae_reg > s1_be_reg;
    end

    always_comb
    begin
        if (s2_neg_reg)
            sum = 35'(s2_a_reg) - 35'(s2_ov_reg);
        else
            sum = 35'(s2_a_reg) + 35'(s2_ov_reg);
        if (!s2_en_reg || s2_ov_reg <= 34'sd0)
            s3_pos_next = s2_a_reg;
        else if (sum[34] && !(&sum[33:31]))
            s3_pos_next = 32'sh8000_0000;
        else if (!sum[34] && (|sum[33:31]))
            s3_pos_next = 32'sh7FFF_FFFF;
        else
            s3_pos_next = sum[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            s1_a_reg  <= s1_a_next;
            s1_b_reg  <= b;
            s1_ae_reg <= s1_ae_next;
            s1_be_reg <= s1_be_next;
            s1_lo_reg <= s1_lo_next;
            s1_ca_reg <= s1_ca_next;
            s1_cb_reg <= s1_cb_next;
            s1_en_reg <= en;
        end
        if (adv.s2)
        begin
            s2_a_reg     <= s1_a_reg;
            s2_ov_reg    <= s2_ov_next;
            s2_neg_reg   <= s2_neg_next;
            s2_en_reg    <= s1_en_reg;
            s2_flags_reg <= s2_flags_next;
        end
        if (adv.s3)
        begin
            s3_pos_reg   <= s3_pos_next;
            s3_flags_reg <= s2_flags_reg;
        end
    end

    assign pos   = s3_pos_reg;
    assign flags = s3_flags_reg;

endmodule

`default_nettype wire

FILE: sv/aabb_collide_resolve_top.sv
`default_nettype none

// box overlap test and push-out: each request carries a moving box and an
// obstacle box (signed Q16.16 corner, unsigned Q15.16 size) and an opcode that
// selects which axes get resolved. one result comes back per request, in order.
// the block takes a new request every cycle unless the output side stalls; the
// rate is set by the three-stage pipeline, one register stage per step of the
// axis math (edge sums, overlap extent, push with saturation), and the last
// stage doubles as the output register. a stall on the output side fills the
// bubbles ahead of it first, so in_ready drops only once all three stages hold
// a request.

module aabb_collide_resolve_top
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic [1:0]         opcode,
    input  wire logic signed [31:0] lhs_x,
    input  wire logic signed [31:0] lhs_y,
    input  wire logic [30:0]        lhs_w,
    input  wire logic [30:0]        lhs_h,
    input  wire logic signed [31:0] rhs_x,
    input  wire logic signed [31:0] rhs_y,
    input  wire logic [30:0]        rhs_w,
    input  wire logic [30:0]        rhs_h,

    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic signed [31:0] new_x,
    output      logic signed [31:0] new_y,
    output      logic               intersects,
    output      logic [2:0]         side
);

    // stage occupancy, travels alongside the data
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;

    aabb_pkg::adv_t adv;

    logic en_x;
    logic en_y;

    aabb_pkg::axis_flags_t fx;
    aabb_pkg::axis_flags_t fy;

    // a stage loads when it is empty or its contents move on this cycle
    always_comb
    begin
        adv.s3 = !v3_reg || out_ready;
        adv.s2 = !v2_reg || adv.s3;
        adv.s1 = !v1_reg || adv.s2;
    end

    assign in_ready = adv.s1;

    always_comb
    begin
        v1_next = adv.s1 ? in_valid : v1_reg;
        v2_next = adv.s2 ? v1_reg   : v2_reg;
        v3_next = adv.s3 ? v2_reg   : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // opcode decode: the unused code resolves neither axis
    always_comb
    begin
        en_x = 1'b0;
        en_y = 1'b0;
        unique case (opcode)
            aabb_pkg::OP_BOTH:
            begin
                en_x = 1'b1;
                en_y = 1'b1;
            end
            aabb_pkg::OP_Y_ONLY: en_y = 1'b1;
            aabb_pkg::OP_X_ONLY: en_x = 1'b1;
            default:
            begin
                en_x = 1'b0;
                en_y = 1'b0;
            end
        endcase
    end

    // the two axes run independently from the original positions
    aabb_axis u_axis_x
    (
        .clk   (clk),
        .adv   (adv),
        .en    (en_x),
        .a     (lhs_x),
        .as    (lhs_w),
        .b     (rhs_x),
        .bs    (rhs_w),
        .pos   (new_x),
        .flags (fx)
    );

    aabb_axis u_axis_y
    (
        .clk   (clk),
        .adv   (adv),
        .en    (en_y),
        .a     (lhs_y),
        .as    (lhs_h),
        .b     (rhs_y),
        .bs    (rhs_h),
        .pos   (new_y),
        .flags (fy)
    );

    assign out_valid = v3_reg;

    // strict overlap on both axes; touching edges do not count
    assign intersects = fx.lo_before_hi && fx.hi_past_lo
                     && fy.lo_before_hi && fy.hi_past_lo;

    // first matching side wins: top, bottom, left, right
    always_comb
    begin
        if (fy.hi_past_lo && fy.lo_before)
            side = aabb_pkg::SIDE_TOP;
        else if (fy.lo_before_hi && fy.hi_past_hi)
            side = aabb_pkg::SIDE_BOTTOM;
        else if (fx.hi_past_lo && fx.lo_before)
            side = aabb_pkg::SIDE_LEFT;
        else if (fx.lo_before_hi && fx.hi_past_hi)
            side = aabb_pkg::SIDE_RIGHT;
        else
            side = aabb_pkg::SIDE_NONE;
    end

    // an accepted request always lands in stage 1
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v1_reg)
        else $error("accepted request not held in stage 1");

    // backpressure reaches the input only with every stage occupied
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> v1_reg && v2_reg && v3_reg && !out_ready)
        else $error("input stalled while pipeline has a bubble");

    // a delivered result is replaced by the request behind it, if any
    a_drain_moves: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && v2_reg |=> out_valid)
        else $error("request lost between stage 2 and output");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
module tb;

    // opcode value that leaves both axes alone, the package names only three
    localparam logic [1:0] OP_NO_AXIS = 2'd3;

    // handy Q16.16 corners and Q15.16 sizes for the directed table
    localparam logic [31:0] P2    = 32'h0002_0000;
    localparam logic [31:0] P5    = 32'h0005_0000;
    localparam logic [31:0] P10   = 32'h000A_0000;
    localparam logic [31:0] P100  = 32'h0064_0000;
    localparam logic [31:0] PMAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] PMIN  = 32'h8000_0000;
    localparam logic [31:0] PMIN1 = 32'h8000_0001;
    localparam logic [31:0] PONES = 32'hFFFF_FFFF;
    localparam logic [30:0] S1    = 31'h0001_0000;
    localparam logic [30:0] S4    = 31'h0004_0000;
    localparam logic [30:0] S10   = 31'h000A_0000;
    localparam logic [30:0] SMAX  = 31'h7FFF_FFFF;

    // saturation bounds in 64-bit arithmetic
    localparam longint Q_HI = longint'(32'sh7FFF_FFFF);
    localparam longint Q_LO = longint'(32'sh8000_0000);

    // requests per random phase, and how long the receiver holds off once
    localparam int PHASE_REQUESTS = 400;
    localparam int HOLD_CYCLES    = 80;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] lhs_x;
        logic [31:0] lhs_y;
        logic [30:0] lhs_w;
        logic [30:0] lhs_h;
        logic [31:0] rhs_x;
        logic [31:0] rhs_y;
        logic [30:0] rhs_w;
        logic [30:0] rhs_h;
    } box_req_t;

    typedef struct packed {
        logic [31:0] new_x;
        logic [31:0] new_y;
        logic        intersects;
        logic [2:0]  side;
    } box_res_t;

    // one row of the directed table: a request and, where it is obvious, its result
    typedef struct packed {
        box_req_t req;
        logic     pinned;
        box_res_t want;
    } dir_row_t;

    // idling schemes, walked in this order by the random part
    typedef enum int {
        PH_STEADY,
        PH_SRC_GAPS,
        PH_SINK_STALLS,
        PH_BOTH_LIGHT
    } idle_phase_t;

    localparam box_res_t NO_PIN = '0;
    localparam int DIR_ROWS = 20;

    // clock, reset and block ports; the ones the bench drives are known from time zero
    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic [1:0]         opcode     = '0;
    logic signed [31:0] lhs_x      = '0;
    logic signed [31:0] lhs_y      = '0;
    logic [30:0]        lhs_w      = '0;
    logic [30:0]        lhs_h      = '0;
    logic signed [31:0] rhs_x      = '0;
    logic signed [31:0] rhs_y      = '0;
    logic [30:0]        rhs_w      = '0;
    logic [30:0]        rhs_h      = '0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic               intersects;
    logic [2:0]         side;

    // results owed by the block, oldest first
    box_res_t    pending_results[$];
    int          failures      = 0;
    idle_phase_t phase         = PH_STEADY;
    logic        hold_request  = 1'b0;

    // directed requests: order is opcode, lhs x y w h, rhs x y w h
    dir_row_t dir_table [DIR_ROWS] = '{
        // both boxes empty at the origin
        '{'{aabb_pkg::OP_BOTH, 32'h0, 32'h0, 31'h0, 31'h0, 32'h0, 32'h0, 31'h0, 31'h0},
          1'b1, '{32'h0, 32'h0, 1'b0, aabb_pkg::SIDE_NONE}},
        // no axis resolved, corner overlap reads as top
        '{'{OP_NO_AXIS, 32'h0, 32'h0, S10, S10, P5, P5, S10, S10},
          1'b1, '{32'h0, 32'h0, 1'b1, aabb_pkg::SIDE_TOP}},
        // same pair through each resolving opcode
        '{'{aabb_pkg::OP_BOTH, 32'h0, 32'h0, S10, S10, P5, P5, S10, S10},
          1'b0, NO_PIN},
        '{'{aabb_pkg::OP_Y_ONLY, 32'h0, 32'h0, S10, S10, P5, P5, S10, S10},
          1'b0, NO_PIN},
        '{'{aabb_pkg::OP_X_ONLY, 32'h0, 32'h0, S10, S10, P5, P5, S10, S10},
          1'b0, NO_PIN},
        // bottom, left and right overlaps
        '{'{aabb_pkg::OP_BOTH, 32'h0, P5, S10, S10, 32'h0, 32'h0, S10, S10},
          1'b0, NO_PIN},
        '{'{aabb_pkg::OP_BOTH, 32'h0, 32'h0, S10, S10, P5, 32'h0, S10, S10},
          1'b0, NO_PIN},
        '{'{aabb_pkg::OP_BOTH, P5, 32'h0, S10, S10, 32'h0, 32'h0, S10, S10},
          1'b0, NO_PIN},
        // moving box fully inside the obstacle
        '{'{aabb_pkg::OP_BOTH, P2, P2, S4, S4, 32'h0, 32'h0, S10, S10},
          1'b0, NO_PIN},
        // equal centres push towards positive
        '{'{aabb_pkg::OP_BOTH, 32'h0, 32'h0, S10, S10, 32'h0, 32'h0, S10, S10},
          1'b0, NO_PIN},
        // touching edges on x are no overlap
        '{'{aabb_pkg::OP_BOTH, 32'h0, 32'h0, S10, S10, P10, 32'h0, S10, S10},
          1'b0, NO_PIN},
        // far apart, negative extent on both axes
        '{'{aabb_pkg::OP_BOTH, 32'h0, 32'h0, S1, S1, P100, P100, S1, S1},
          1'b0, NO_PIN},
        // push past the top bound saturates
        '{'{aabb_pkg::OP_X_ONLY, PMAX, 32'h0, SMAX, 31'h0, PMAX, 32'h0, SMAX, 31'h0},
          1'b1, '{PMAX, 32'h0, 1'b0, aabb_pkg::SIDE_NONE}},
        // push past the bottom bound saturates, x then y
        '{'{aabb_pkg::OP_X_ONLY, PMIN, 32'h0, SMAX, 31'h0, PMIN1, 32'h0, SMAX, 31'h0},
          1'b0, NO_PIN},
        '{'{aabb_pkg::OP_Y_ONLY, 32'h0, PMIN, 31'h0, SMAX, 32'h0, PMIN1, 31'h0, SMAX},
          1'b0, NO_PIN},
        // all ones: identical boxes, first with no axis resolved, then with both
        '{'{OP_NO_AXIS, PONES, PONES, SMAX, SMAX, PONES, PONES, SMAX, SMAX},
          1'b1, '{PONES, PONES, 1'b1, aabb_pkg::SIDE_NONE}},
        '{'{aabb_pkg::OP_BOTH, PONES, PONES, SMAX, SMAX, PONES, PONES, SMAX, SMAX},
          1'b0, NO_PIN},
        // opposite corners of the range
        '{'{aabb_pkg::OP_BOTH, PMIN, PMIN, 31'h0, 31'h0, PMAX, PMAX, SMAX, SMAX},
          1'b0, NO_PIN},
        '{'{aabb_pkg::OP_BOTH, PMAX, PMAX, SMAX, SMAX, PMIN, PMIN, SMAX, SMAX},
          1'b0, NO_PIN},
        // fractional sizes and negative corners
        '{'{aabb_pkg::OP_BOTH, 32'h0000_8000, 32'hFFFF_8000, 31'h0000_C000, 31'h0001_4000,
            32'h0, 32'hFFFF_0000, 31'h0000_4000, 31'h0002_0000}, 1'b0, NO_PIN}
    };

    aabb_collide_resolve_top dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .lhs_x      (lhs_x),
        .lhs_y      (lhs_y),
        .lhs_w      (lhs_w),
        .lhs_h      (lhs_h),
        .rhs_x      (rhs_x),
        .rhs_y      (rhs_y),
        .rhs_w      (rhs_w),
        .rhs_h      (rhs_h),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .new_x      (new_x),
        .new_y      (new_y),
        .intersects (intersects),
        .side       (side)
    );

    // push one axis of the moving box out of the obstacle, saturated to 32 bits
    function automatic logic [31:0] resolve_axis(input logic [31:0] pos, input logic [30:0] len,
                                                 input logic [31:0] opos, input logic [30:0] olen);
        longint p, l, q, m, lo, hi, ov, moved;
        p = longint'($signed(pos));
        l = longint'(len);
        q = longint'($signed(opos));
        m = longint'(olen);
        lo = (p > q) ? p : q;
        hi = (p + l < q + m) ? p + l : q + m;
        ov = hi - lo;
        // touching or apart: axis left alone
        if (ov <= 0)
            return pos;
        // centres compared doubled, ties move towards positive
        moved = (2 * p + l < 2 * q + m) ? p - ov : p + ov;
        if (moved > Q_HI)
            return PMAX;
        if (moved < Q_LO)
            return PMIN;
        return moved[31:0];
    endfunction

    // full result of one request: new corner, hit flag and first matching side
    function automatic box_res_t predict_resolution(input box_req_t r);
        box_res_t e;
        longint   lx, ly, lw, lh, rx, ry, rw, rh;
        lx = longint'($signed(r.lhs_x));
        ly = longint'($signed(r.lhs_y));
        lw = longint'(r.lhs_w);
        lh = longint'(r.lhs_h);
        rx = longint'($signed(r.rhs_x));
        ry = longint'($signed(r.rhs_y));
        rw = longint'(r.rhs_w);
        rh = longint'(r.rhs_h);
        e.new_x = r.lhs_x;
        e.new_y = r.lhs_y;
        if (r.opcode == aabb_pkg::OP_BOTH || r.opcode == aabb_pkg::OP_X_ONLY)
            e.new_x = resolve_axis(r.lhs_x, r.lhs_w, r.rhs_x, r.rhs_w);
        if (r.opcode == aabb_pkg::OP_BOTH || r.opcode == aabb_pkg::OP_Y_ONLY)
            e.new_y = resolve_axis(r.lhs_y, r.lhs_h, r.rhs_y, r.rhs_h);
        e.intersects = (lx < rx + rw) && (lx + lw > rx) && (ly < ry + rh) && (ly + lh > ry);
        if (ly + lh > ry && ly < ry)
            e.side = aabb_pkg::SIDE_TOP;
        else if (ly < ry + rh && ly + lh > ry + rh)
            e.side = aabb_pkg::SIDE_BOTTOM;
        else if (lx + lw > rx && lx < rx)
            e.side = aabb_pkg::SIDE_LEFT;
        else if (lx < rx + rw && lx + lw > rx + rw)
            e.side = aabb_pkg::SIDE_RIGHT;
        else
            e.side = aabb_pkg::SIDE_NONE;
        return e;
    endfunction

    // a corner within 2^24 of either end of the signed range
    function automatic logic [31:0] near_bound();
        logic [31:0] off;
        off = 32'($urandom_range(0, 32'h00FF_FFFF));
        return $urandom_range(0, 1) ? PMAX - off : PMIN + off;
    endfunction

    function automatic logic [30:0] big_size();
        return $urandom_range(0, 1) ? SMAX - 31'($urandom_range(0, 32'h00FF_FFFF))
                                    : 31'($urandom);
    endfunction

    // random request: mostly near pairs that may overlap, then raw noise, then extremes
    function automatic box_req_t random_request();
        box_req_t    r;
        logic [31:0] span;
        int unsigned kind;
        kind = $urandom_range(0, 99);
        r.opcode = ($urandom_range(0, 9) == 0) ? OP_NO_AXIS : 2'($urandom_range(0, 2));
        if (kind < 65)
        begin
            // obstacle placed within one span of the moving box
            span = 32'd1 << $urandom_range(2, 23);
            r.lhs_x = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
            r.lhs_y = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
            r.lhs_w = 31'($urandom_range(0, span));
            r.lhs_h = 31'($urandom_range(0, span));
            r.rhs_x = r.lhs_x + 32'($urandom_range(0, 2 * span)) - span;
            r.rhs_y = r.lhs_y + 32'($urandom_range(0, 2 * span)) - span;
            r.rhs_w = 31'($urandom_range(0, span));
            r.rhs_h = 31'($urandom_range(0, span));
        end
        else if (kind < 85)
        begin
            // every bit free
            r.lhs_x = $urandom;
            r.lhs_y = $urandom;
            r.lhs_w = 31'($urandom);
            r.lhs_h = 31'($urandom);
            r.rhs_x = $urandom;
            r.rhs_y = $urandom;
            r.rhs_w = 31'($urandom);
            r.rhs_h = 31'($urandom);
        end
        else
        begin
            // near the range bounds, where pushes saturate
            r.lhs_x = near_bound();
            r.lhs_y = near_bound();
            r.lhs_w = big_size();
            r.lhs_h = big_size();
            r.rhs_x = near_bound();
            r.rhs_y = near_bound();
            r.rhs_w = big_size();
            r.rhs_h = big_size();
        end
        return r;
    endfunction

    function automatic bit source_gaps();
        case (phase)
            PH_SRC_GAPS:   return $urandom_range(0, 99) < 82;
            PH_BOTH_LIGHT: return $urandom_range(0, 99) < 14;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic bit sink_stalls();
        case (phase)
            PH_SINK_STALLS: return $urandom_range(0, 99) < 82;
            PH_BOTH_LIGHT:  return $urandom_range(0, 99) < 14;
            default:        return 1'b0;
        endcase
    endfunction

    // offer one request and hold it until the block takes it; valid is only
    // lowered during a gap so it never gets two updates in one step
    task automatic offer(input box_req_t r, input logic pinned, input box_res_t want);
        while (source_gaps())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= r.opcode;
        lhs_x    <= r.lhs_x;
        lhs_y    <= r.lhs_y;
        lhs_w    <= r.lhs_w;
        lhs_h    <= r.lhs_h;
        rhs_x    <= r.rhs_x;
        rhs_y    <= r.rhs_y;
        rhs_w    <= r.rhs_w;
        rhs_h    <= r.rhs_h;
        do
            @(posedge clk);
        while (!in_ready);
        // request taken at this edge
        pending_results.push_back(pinned ? want : predict_resolution(r));
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            failures++;
            if (failures <= 10)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    // result taken at this edge: match it against the oldest owed one
    task automatic check_result();
        box_res_t want;
        if (pending_results.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("result with no request behind it: new_x %h new_y %h", new_x, new_y);
            return;
        end
        want = pending_results.pop_front();
        compare_field("new_x", want.new_x, new_x);
        compare_field("new_y", want.new_y, new_y);
        compare_field("intersects", 32'(want.intersects), 32'(intersects));
        compare_field("side", 32'(want.side), 32'(side));
    endtask

    // free-running clock, period 2
    initial
    begin
        forever
            #1 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: checks every accepted result, stalls per phase, and holds
    // off for a long stretch once when asked
    initial
    begin
        int hold_left;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_result();
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !sink_stalls();
        end
    end

    // sender: reset, directed table, then the random phases
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows with no idling
        phase = PH_STEADY;
        for (int i = 0; i < DIR_ROWS; i++)
            offer(dir_table[i].req, dir_table[i].pinned, dir_table[i].want);

        // the steady phase starts with the receiver held off so that the
        // pipeline fills and back-pressure reaches the request side
        hold_request = 1'b1;
        for (int p = 0; p < 4; p++)
        begin
            phase = idle_phase_t'(p);
            repeat (PHASE_REQUESTS)
                offer(random_request(), 1'b0, NO_PIN);
        end
        in_valid <= 1'b0;

        // drain, then clock on to catch stray results
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
sv/aabb_pkg.sv
sv/aabb_axis.sv
sv/aabb_collide_resolve_top.sv
tb/sv/tb.sv
